FILE: rtl/bsfs_pkg.sv
// Shared types, constants and register indexes for the balance feedback step.
package bsfs_pkg;

	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_RATE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_RATE_INT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_SPEED = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_POSITION = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_COMMAND = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_ZERO = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_ZERO = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_WEIGHT = 8'd7;

	localparam logic signed [31:0] POLY_C0 = 32'sd78355;
	localparam logic signed [31:0] POLY_C1 = 32'sd508;
	// The divisor 1416 is 8 * 177; this is ceil(2^24 / 177).
	localparam logic [33:0] DIV_RECIP = 34'd94787;
	localparam logic [9:0] TILT_LOW = 10'd156;
	localparam logic [9:0] TILT_HIGH = 10'd623;
	localparam logic signed [15:0] TILT_BAD = 16'sd30000;
	localparam logic signed [31:0] PHI_LOW = 32'sd1500 - 32'sd20550;
	localparam logic signed [31:0] PHI_HIGH = 32'sd1500 + 32'sd20550;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_DIV,
		ST_CUBE,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_FUSE1,
		ST_FUSE2,
		ST_FINISH,
		ST_OUT
	} state_t;

	// Datapath step commands.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQ,
		OP_DIV,
		OP_CUBE,
		OP_M0,
		OP_M1,
		OP_M2,
		OP_M3,
		OP_M4,
		OP_FUSE1,
		OP_FUSE2,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
		logic div_start;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
	} status_t;

endpackage

FILE: rtl/bsfs_if.sv
// Valid/ready channel interfaces for data words and configuration writes.
interface bsfs_in_if;
	logic valid;
	logic ready;
	logic [9:0] tilt_sample;
	logic [9:0] rate_sample;
	logic [9:0] accel_sample;
	logic signed [15:0] wheel_speed;
	logic signed [31:0] wheel_position;
	logic signed [4:0] req_speed;
	logic switch_on;
	modport source (output valid, tilt_sample, rate_sample, accel_sample, wheel_speed,
		wheel_position, req_speed, switch_on, input ready);
	modport sink (input valid, tilt_sample, rate_sample, accel_sample, wheel_speed,
		wheel_position, req_speed, switch_on, output ready);
endinterface

interface bsfs_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] speed_target;
	logic enabled;
	logic restarted;
	logic signed [15:0] tilt_angle;
	logic signed [31:0] user_position;
	modport source (output valid, speed_target, enabled, restarted, tilt_angle,
		user_position, input ready);
	modport sink (input valid, speed_target, enabled, restarted, tilt_angle,
		user_position, output ready);
endinterface

interface bsfs_cfg_if;
	logic valid;
	logic ready;
	logic [7:0] index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/bsfs_div.sv
// Quotient of the tilt sample square by the polynomial divisor, by reciprocal multiplication.
module bsfs_div
	import bsfs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [19:0] dividend,
	output logic busy,
	output logic [19:0] quotient
);
	logic [33:0] prod;
	logic [9:0] quo_q;

	// The low three bits drop out with the factor of eight; the reciprocal
	// of 177 is exact for every 17-bit value that remains.
	assign prod = {17'd0, dividend[19:3]} * DIV_RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
		end else if (start) begin
			quo_q <= prod[33:24];
		end
	end

	assign busy = start;
	assign quotient = {10'd0, quo_q};
endmodule

FILE: rtl/bsfs_datapath.sv
// Datapath: shared multiplier, accumulators, fusion integral and output word.
module bsfs_datapath
	import bsfs_pkg::*;
#(
	parameter int unsigned CNT_W = 7,
	parameter logic [CNT_W-1:0] ENABLE_TICKS = 7'd100
)
(
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output status_t status,
	bsfs_in_if.sink in_ch,
	bsfs_cfg_if.sink cfg_ch,
	output logic signed [15:0] speed_target_q,
	output logic enabled_q,
	output logic restarted_q,
	output logic signed [15:0] tilt_angle_q,
	output logic signed [31:0] user_position_q
);
	logic [15:0] gain_q [5];
	logic [9:0] rate_zero_q;
	logic [9:0] accel_zero_q;
	logic [14:0] accel_weight_q;

	logic [31:0] speed_acc_q;
	logic [31:0] tilt_int_q;
	logic [31:0] user_pos_q;
	logic active_q;
	logic [CNT_W-1:0] good_cnt_q;

	logic [9:0] tilt_q;
	logic [9:0] rate_q;
	logic [9:0] accel_q;
	logic [31:0] wspeed_q;
	logic [31:0] wpos_q;
	logic [31:0] uspeed_q;
	logic sw_q;

	logic [31:0] sq_q;
	logic [31:0] poly_q;
	logic [31:0] sum_q;
	logic [31:0] fuse_q;

	logic [31:0] rate_d;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] prod;
	logic [19:0] quo;
	logic div_busy;
	logic signed [15:0] phi;
	logic good;
	logic [31:0] new_acc;
	logic signed [31:0] fuse_diff;
	logic signed [31:0] fuse_step;

	bsfs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(sq_q[19:0]), .busy(div_busy), .quotient(quo)
	);
	assign status.div_busy = div_busy;

	assign rate_d = {22'd0, rate_q} - {22'd0, rate_zero_q};

	// Kept in signed signals so the shift stays arithmetic.
	assign fuse_diff = $signed(fuse_q - tilt_int_q);
	assign fuse_step = fuse_diff >>> 8;

	// One 32x32 multiplier, low word kept, operands steered by the step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQ: begin
				mul_a = {22'd0, tilt_q};
				mul_b = {22'd0, tilt_q};
			end
			OP_CUBE: begin
				mul_a = {12'd0, quo};
				mul_b = {22'd0, tilt_q};
			end
			OP_M0: begin
				mul_a = {{16{gain_q[0][15]}}, gain_q[0]};
				mul_b = rate_d;
			end
			OP_M1: begin
				mul_a = {{16{gain_q[1][15]}}, gain_q[1]};
				mul_b = {{8{tilt_int_q[31]}}, tilt_int_q[31:8]};
			end
			OP_M2: begin
				mul_a = {{16{gain_q[2][15]}}, gain_q[2]};
				mul_b = wspeed_q - uspeed_q;
			end
			OP_M3: begin
				mul_a = {{16{gain_q[3][15]}}, gain_q[3]};
				mul_b = wpos_q - user_pos_q;
			end
			OP_M4: begin
				mul_a = {{16{gain_q[4][15]}}, gain_q[4]};
				mul_b = {{16{speed_acc_q[31]}}, speed_acc_q[31:16]};
			end
			OP_FUSE1: begin
				mul_a = {17'd0, accel_weight_q};
				mul_b = {22'd0, accel_q} - {22'd0, accel_zero_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	always_comb begin
		if (tilt_q < TILT_LOW || tilt_q > TILT_HIGH) begin
			phi = TILT_BAD;
		end else begin
			phi = poly_q[15:0];
		end
		good = ($signed({{16{phi[15]}}, phi}) > PHI_LOW)
			&& ($signed({{16{phi[15]}}, phi}) < PHI_HIGH) && sw_q;
		new_acc = speed_acc_q + sum_q;
	end

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready = (cmd.op == OP_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q[0] <= 16'd5048;
			gain_q[1] <= 16'd211;
			gain_q[2] <= 16'd9807;
			gain_q[3] <= 16'd21;
			gain_q[4] <= 16'hE42A;
			rate_zero_q <= 10'd324;
			accel_zero_q <= 10'd354;
			accel_weight_q <= 15'd7209;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_GAIN_RATE: gain_q[0] <= cfg_ch.data;
				REG_GAIN_RATE_INT: gain_q[1] <= cfg_ch.data;
				REG_GAIN_SPEED: gain_q[2] <= cfg_ch.data;
				REG_GAIN_POSITION: gain_q[3] <= cfg_ch.data;
				REG_GAIN_COMMAND: gain_q[4] <= cfg_ch.data;
				REG_RATE_ZERO: rate_zero_q <= cfg_ch.data[9:0];
				REG_ACCEL_ZERO: accel_zero_q <= cfg_ch.data[9:0];
				REG_ACCEL_WEIGHT: accel_weight_q <= cfg_ch.data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				tilt_q <= in_ch.tilt_sample;
				rate_q <= in_ch.rate_sample;
				accel_q <= in_ch.accel_sample;
				wspeed_q <= {{16{in_ch.wheel_speed[15]}}, in_ch.wheel_speed};
				wpos_q <= in_ch.wheel_position;
				uspeed_q <= {{27{in_ch.req_speed[4]}}, in_ch.req_speed};
				sw_q <= in_ch.switch_on;
			end
			OP_SQ: begin
				sq_q <= prod;
				poly_q <= POLY_C1 * $signed({22'd0, tilt_q}) - POLY_C0;
			end
			OP_DIV: poly_q <= poly_q - sq_q;
			OP_CUBE: poly_q <= poly_q + prod;
			OP_M0: sum_q <= prod;
			OP_M1, OP_M2, OP_M3, OP_M4: sum_q <= sum_q + prod;
			OP_FUSE1: fuse_q <= prod;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_acc_q <= '0;
			tilt_int_q <= '0;
			user_pos_q <= '0;
			active_q <= 1'b0;
			good_cnt_q <= '0;
			speed_target_q <= '0;
			enabled_q <= 1'b0;
			restarted_q <= 1'b0;
			tilt_angle_q <= '0;
			user_position_q <= '0;
		end else begin
			case (cmd.op)
				OP_FUSE1: tilt_int_q <= tilt_int_q + {rate_d[23:0], 8'd0};
				OP_FUSE2: tilt_int_q <= tilt_int_q + fuse_step;
				OP_FINISH: begin
					logic [31:0] acc;
					logic [31:0] upos;
					logic act;
					logic [CNT_W-1:0] cnt;
					logic rs;
					logic [15:0] tgt;
					acc = speed_acc_q;
					upos = user_pos_q;
					act = active_q;
					cnt = good_cnt_q;
					rs = 1'b0;
					tgt = '0;
					if (active_q) begin
						acc = new_acc;
						upos = user_pos_q + uspeed_q;
						tgt = new_acc[31:16];
					end
					if (good) begin
						if (cnt < ENABLE_TICKS) begin
							cnt = cnt + 1'b1;
						end
					end else begin
						act = 1'b0;
						cnt = '0;
					end
					if (!act && cnt >= ENABLE_TICKS) begin
						act = 1'b1;
						acc = '0;
						upos = '0;
						rs = 1'b1;
					end
					speed_acc_q <= acc;
					user_pos_q <= upos;
					active_q <= act;
					good_cnt_q <= cnt;
					speed_target_q <= tgt;
					enabled_q <= act;
					restarted_q <= rs;
					tilt_angle_q <= phi;
					user_position_q <= upos;
				end
				default: ;
			endcase
		end
	end
endmodule

FILE: rtl/bsfs_ctrl.sv
// Controller: steps one word through the datapath and holds the result word.
module bsfs_ctrl
	import bsfs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic out_ready,
	input  status_t status,
	output cmd_t cmd,
	output logic out_valid
);
	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		cmd.div_start = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.op = OP_SQ;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV;
				cmd.div_start = 1'b1;
				state_d = ST_CUBE;
			end
			ST_CUBE: begin
				if (!status.div_busy) begin
					cmd.op = OP_CUBE;
					state_d = ST_M0;
				end
			end
			ST_M0: begin
				cmd.op = OP_M0;
				state_d = ST_M1;
			end
			ST_M1: begin
				cmd.op = OP_M1;
				state_d = ST_M2;
			end
			ST_M2: begin
				cmd.op = OP_M2;
				state_d = ST_M3;
			end
			ST_M3: begin
				cmd.op = OP_M3;
				state_d = ST_M4;
			end
			ST_M4: begin
				cmd.op = OP_M4;
				state_d = ST_FUSE1;
			end
			ST_FUSE1: begin
				cmd.op = OP_FUSE1;
				state_d = ST_FUSE2;
			end
			ST_FUSE2: begin
				cmd.op = OP_FUSE2;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.op = OP_FINISH;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

FILE: rtl/balance_state_feedback_step.sv
// Top level of the balance state-feedback step.
//  channel  | dir | handshake   | word
//  in_ch    | in  | valid/ready | tilt, rate, accel, wheel speed/pos, requested speed, switch
//  out_ch   | out | valid/ready | speed target, enabled, restarted, tilt angle, user pos
//  cfg_ch   | in  | valid/ready | register index, 16-bit data
// A result is valid once its word has gone through the steps on the shared multiplier and the
// registered reciprocal quotient for the cubic term.
// Reset loads the register defaults and clears the speed accumulator, tilt integral, user position and the count.
// A result waits in the output register until taken; the next word is accepted
// only after that. Configuration writes are always taken.
module balance_state_feedback_step
	import bsfs_pkg::*;
#(
	parameter int unsigned ENABLE_TICKS = 100
)
(
	input  logic clk,
	input  logic arst_n,
	bsfs_in_if.sink in_ch,
	bsfs_out_if.source out_ch,
	bsfs_cfg_if.sink cfg_ch
);
	cmd_t cmd;
	status_t status;

	bsfs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .out_ready(out_ch.ready),
		.status(status), .cmd(cmd), .out_valid(out_ch.valid)
	);

	bsfs_datapath #(
		.CNT_W(7), .ENABLE_TICKS(7'(ENABLE_TICKS))
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.in_ch(in_ch), .cfg_ch(cfg_ch),
		.speed_target_q(out_ch.speed_target), .enabled_q(out_ch.enabled),
		.restarted_q(out_ch.restarted), .tilt_angle_q(out_ch.tilt_angle),
		.user_position_q(out_ch.user_position)
	);
endmodule
